// ----- src/bmpu_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpu_pkg
// Shared types, constants and the CORDIC arctangent table of the pose update.
// ----------------------------------------------------------------------------
package bmpu_pkg;

    // CORDIC datapath width (Q2.30 with headroom)
    localparam int CW      = 34;
    localparam int TAB_LEN = 24;

    // serial divider: dividend magnitude bits, divisor bits
    localparam int DIV_N = 52;
    localparam int DIV_M = 32;

    // tangent in Q16, signed; bounded by the steering clamp
    localparam int TQ_W = 28;

    // shared multiplier operand widths
    localparam int MUL_A_W = 29;
    localparam int MUL_B_W = 35;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [CW-1:0]      CORDIC_GAIN = 34'sd652032874;
    // 2^32 / (2*pi), rounded
    localparam logic signed [MUL_B_W-1:0] RAD_TO_TURN = 35'sd683565276;
    localparam logic signed [14:0]        STEER_LIMIT = 15'sd16000;
    localparam logic [15:0]               AXLE_RESET  = 16'd5120;

    localparam logic OP_MOVE = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // register index (bit 2 of the byte address)
    localparam logic REG_AXLE = 1'b0;

    typedef enum logic [4:0] {
        S_IDLE,
        S_C1_GO,
        S_C1_WAIT,
        S_TDIV_GO,
        S_TDIV_WAIT,
        S_M1,
        S_RDIV_GO,
        S_RDIV_WAIT,
        S_M2,
        S_M3,
        S_HEAD,
        S_C2_GO,
        S_C2_WAIT,
        S_MX,
        S_MY,
        S_PY,
        S_DONE
    } state_t;

    typedef struct packed {
        logic signed [CW-1:0] cos_v;
        logic signed [CW-1:0] sin_v;
    } cordic_res_t;

    // atan(2^-i) in 2^32 units per turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = 32'h00000000;
            endcase
            atan_turn = v;
        end
    endfunction

endpackage

// ----- src/bicycle_model_pose_update_unit.sv -----
// ----------------------------------------------------------------------------
// bicycle_model_pose_update_unit
// Kinematic bicycle odometry: keeps x, y and heading and updates them per beat.
// ----------------------------------------------------------------------------
// A set beat (tuser = 1) loads x, y and heading and goes straight to the done
// state, which writes the result to the output register once that is free. A
// move beat (tuser = 0) takes two passes of the iterative CORDIC (one
// micro-rotation per cycle), two passes of the bit-serial divider (for the
// tangent and for the division by the wheelbase) and five trips through the
// single registered multiplier. The input side is ready only while the
// sequencer is idle; a finished result sits in an output register, so the
// next beat is taken while it waits.
// Heading is a 16-bit binary angle that wraps; x and y saturate.
// ----------------------------------------------------------------------------
module bicycle_model_pose_update_unit
    import bmpu_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,

    // input beats
    input  logic         s_tvalid,
    output logic         s_tready,
    // [15:0] distance, [30:16] steering_angle, [62:31] new_x,
    // [94:63] new_y, [110:95] new_heading, [111] zero
    input  logic [111:0] s_tdata,
    // [0] operation
    input  logic [0:0]   s_tuser,

    // result beats
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] pose_x, [63:32] pose_y, [79:64] pose_heading
    output logic [79:0]  m_tdata,

    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    // ------------------------------------------------------------------
    // state and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [15:0]               axle_reg;
    logic signed [31:0]        pos_x_reg;
    logic signed [31:0]        pos_y_reg;
    logic [15:0]               heading_reg;
    logic                      out_valid_reg;
    logic [79:0]               out_data_reg;

    logic signed [15:0]        dist_reg;
    logic signed [14:0]        steer_reg;
    logic signed [CW-1:0]      cos_reg;
    logic signed [CW-1:0]      sin_reg;
    logic                      neg_reg;
    logic signed [TQ_W-1:0]    tq_reg;
    logic [55:0]               rad_reg;
    logic [55:0]               p1_reg;

    // ------------------------------------------------------------------
    // shared unit hookup
    // ------------------------------------------------------------------
    logic                      cordic_start;
    logic [15:0]               cordic_angle;
    cordic_res_t               cordic_res;
    logic                      cordic_done;

    logic                      div_start;
    logic [DIV_N-1:0]          div_dividend;
    logic [DIV_M-1:0]          div_divisor;
    logic [DIV_N-1:0]          div_quotient;
    logic                      div_done;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    bmpu_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (cordic_angle),
        .res   (cordic_res),
        .done  (cordic_done)
    );

    bmpu_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    bmpu_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // ------------------------------------------------------------------
    // input decode
    // ------------------------------------------------------------------
    logic               in_accept;
    logic signed [14:0] steer_in;
    logic signed [14:0] steer_sat;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign steer_in  = $signed(s_tdata[30:16]);

    always_comb
    begin
        if (steer_in > STEER_LIMIT)
            steer_sat = STEER_LIMIT;
        else if (steer_in < -STEER_LIMIT)
            steer_sat = -STEER_LIMIT;
        else
            steer_sat = steer_in;
    end

    // ------------------------------------------------------------------
    // datapath helpers
    // ------------------------------------------------------------------
    logic [CW-1:0]        abs_sin;
    logic [MUL_P_W-1:0]   abs_prod;
    logic [DIV_N-1:0]     quo_signed;
    logic [55:0]          head_sum;
    logic signed [63:0]   step_round;
    logic signed [33:0]   step;
    logic signed [33:0]   sum_x;
    logic signed [33:0]   sum_y;

    assign abs_sin  = sin_reg[CW-1] ? -sin_reg : sin_reg;
    assign abs_prod = mul_p[MUL_P_W-1] ? -mul_p : mul_p;
    assign quo_signed = neg_reg ? -div_quotient : div_quotient;

    // turn = bits [55:40] of rad * RAD_TO_TURN + 2^39, product taken mod 2^56
    assign head_sum = p1_reg + {mul_p[27:0], 28'b0} + (56'd1 << 39);

    // floor((d * trig + 2^21) / 2^22)
    assign step_round = mul_p + 64'sd2097152;
    assign step       = step_round[55:22];
    assign sum_x      = {{2{pos_x_reg[31]}}, pos_x_reg} + step;
    assign sum_y      = {{2{pos_y_reg[31]}}, pos_y_reg} + step;

    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647)
                sat32 = 32'h7FFF_FFFF;
            else if (v < -34'sd2147483648)
                sat32 = 32'h8000_0000;
            else
                sat32 = v[31:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = (s_tuser[0] == OP_SET) ? S_DONE : S_C1_GO;
            end
            S_C1_GO:     state_next = S_C1_WAIT;
            S_C1_WAIT:   if (cordic_done) state_next = S_TDIV_GO;
            S_TDIV_GO:   state_next = S_TDIV_WAIT;
            S_TDIV_WAIT: if (div_done) state_next = S_M1;
            S_M1:        state_next = S_RDIV_GO;
            S_RDIV_GO:   state_next = S_RDIV_WAIT;
            S_RDIV_WAIT: if (div_done) state_next = S_M2;
            S_M2:        state_next = S_M3;
            S_M3:        state_next = S_HEAD;
            S_HEAD:      state_next = S_C2_GO;
            S_C2_GO:     state_next = S_C2_WAIT;
            S_C2_WAIT:   if (cordic_done) state_next = S_MX;
            S_MX:        state_next = S_MY;
            S_MY:        state_next = S_PY;
            S_PY:        state_next = S_DONE;
            S_DONE:      if (!out_valid_reg || m_tready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: unit controls and operand select
    // ------------------------------------------------------------------
    always_comb
    begin
        cordic_start = 1'b0;
        cordic_angle = heading_reg;
        div_start    = 1'b0;
        div_dividend = {2'b00, abs_sin, 16'b0};
        div_divisor  = (cos_reg <= 0) ? 32'd1 : cos_reg[31:0];
        mul_a        = MUL_A_W'(dist_reg);
        mul_b        = MUL_B_W'(cos_reg);
        unique case (state_reg)
            S_C1_GO:
            begin
                cordic_start = 1'b1;
                cordic_angle = {steer_reg[14], steer_reg};
            end
            S_C2_GO:
            begin
                cordic_start = 1'b1;
            end
            S_TDIV_GO:
            begin
                div_start = 1'b1;
            end
            S_RDIV_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {abs_prod[43:0], 8'b0};
                div_divisor  = (axle_reg == 16'd0) ? 32'd1 : {16'b0, axle_reg};
            end
            S_M1:
            begin
                mul_b = MUL_B_W'(tq_reg);
            end
            S_M2:
            begin
                mul_a = $signed({1'b0, rad_reg[27:0]});
                mul_b = RAD_TO_TURN;
            end
            S_M3:
            begin
                mul_a = $signed({1'b0, rad_reg[55:28]});
                mul_b = RAD_TO_TURN;
            end
            S_MY:
            begin
                mul_b = MUL_B_W'(sin_reg);
            end
            default:
            begin
                cordic_start = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control and pose state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axle_reg      <= AXLE_RESET;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (psel && penable && pwrite && (paddr[2] == REG_AXLE))
                axle_reg <= pwdata[15:0];

            if (in_accept && (s_tuser[0] == OP_SET))
            begin
                pos_x_reg   <= $signed(s_tdata[62:31]);
                pos_y_reg   <= $signed(s_tdata[94:63]);
                heading_reg <= s_tdata[110:95];
            end

            if (state_reg == S_HEAD)
                heading_reg <= heading_reg + head_sum[55:40];
            if (state_reg == S_MY)
                pos_x_reg <= sat32(sum_x);
            if (state_reg == S_PY)
                pos_y_reg <= sat32(sum_y);

            if ((state_reg == S_DONE) && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // working registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dist_reg  <= $signed(s_tdata[15:0]);
            steer_reg <= steer_sat;
        end

        if (((state_reg == S_C1_WAIT) || (state_reg == S_C2_WAIT)) && cordic_done)
        begin
            cos_reg <= cordic_res.cos_v;
            sin_reg <= cordic_res.sin_v;
        end

        // sign of the truncating divisions
        if (state_reg == S_TDIV_GO)
            neg_reg <= sin_reg[CW-1];
        if (state_reg == S_RDIV_GO)
            neg_reg <= mul_p[MUL_P_W-1];

        if ((state_reg == S_TDIV_WAIT) && div_done)
            tq_reg <= $signed(quo_signed[TQ_W-1:0]);
        if ((state_reg == S_RDIV_WAIT) && div_done)
            rad_reg <= {{(56 - DIV_N){quo_signed[DIV_N-1]}}, quo_signed};

        if (state_reg == S_M3)
            p1_reg <= mul_p[55:0];

        if ((state_reg == S_DONE) && (!out_valid_reg || m_tready))
            out_data_reg <= {heading_reg, pos_y_reg, pos_x_reg};
    end

    // ------------------------------------------------------------------
    // outputs
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_AXLE) ? {16'b0, axle_reg} : 32'b0;

endmodule

// ----- src/bmpu_cordic.sv -----
// ----------------------------------------------------------------------------
// bmpu_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module bmpu_cordic
    import bmpu_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] angle,
    output cordic_res_t res,
    output logic        done
);

    localparam int IW = $clog2(STEPS);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [IW-1:0]        iter_reg, iter_next;
    logic                 flip_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;

    logic                 flip;
    logic [31:0]          a_fold;
    logic signed [CW-1:0] dx, dy, at;

    // fold second and third quadrant by a half turn
    assign flip   = angle[15] ^ angle[14];
    assign a_fold = {angle[15] ^ flip, angle[14:0], 16'b0};

    assign dx = y_reg >>> iter_reg;
    assign dy = x_reg >>> iter_reg;
    assign at = $signed({2'b00, atan_turn(5'(iter_reg))});

    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
        end
        else if (busy_reg)
        begin
            if (iter_reg == IW'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                iter_next = iter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            flip_reg <= flip;
            x_reg    <= CORDIC_GAIN;
            y_reg    <= '0;
            z_reg    <= $signed({{2{a_fold[31]}}, a_fold});
        end
        else if (busy_reg)
        begin
            if (!z_reg[CW-1])
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign res.cos_v = flip_reg ? -x_reg : x_reg;
    assign res.sin_v = flip_reg ? -y_reg : y_reg;
    assign done      = done_reg;

endmodule

// ----- src/bmpu_divider.sv -----
// ----------------------------------------------------------------------------
// bmpu_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bmpu_divider
    import bmpu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_N-1:0] dividend,
    input  logic [DIV_M-1:0] divisor,
    output logic [DIV_N-1:0] quotient,
    output logic             done
);

    localparam int NW = $clog2(DIV_N);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NW-1:0]    cnt_reg, cnt_next;
    logic [DIV_M-1:0] dvs_reg;
    logic [DIV_M-1:0] rem_reg;
    logic [DIV_N-1:0] quo_reg;

    logic [DIV_M:0]   trial;
    logic [DIV_M:0]   diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DIV_N-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == NW'(DIV_N - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // quo_reg shifts dividend bits out at the top and quotient bits in below
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_M-1:0] : trial[DIV_M-1:0];
            quo_reg <= {quo_reg[DIV_N-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- src/bmpu_mul.sv -----
// ----------------------------------------------------------------------------
// bmpu_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module bmpu_mul
    import bmpu_pkg::*;
(
    input  logic                       clk,
    input  logic signed [MUL_A_W-1:0]  a,
    input  logic signed [MUL_B_W-1:0]  b,
    output logic signed [MUL_P_W-1:0]  p
);

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule
